/* design/swm_pkg.sv */
// Package for the sliding window median filter.
// Holds the state and cell command codes, flag struct and fixed widths.
// No dependencies; the other files that use it refer to it by scoped names.
package swm_pkg;

  // Width of the window size register.
  localparam int WSIZE_BITS = 7;

  // Window size after reset.
  localparam logic [WSIZE_BITS-1:0] WSIZE_RESET = 7'd3;

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DELETE,
    ST_INSERT,
    ST_RESULT
  } state_t;

  // Command broadcast to every cell of the sorted row.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_INSERT,
    CELL_DELETE
  } cell_cmd_t;

  // Status a cell shows to its neighbors.
  typedef struct packed {
    logic valid;  // cell holds a window sample
    logic stay;   // holds a sample not above the incoming one
    logic eq;     // holds a sample equal to the leaving one
  } cell_flags_t;

endpackage

/* design/swm_cell.sv */
// One cell of the sorted row: a sample and its valid bit.
// Depends on swm_pkg for the command code and neighbor flags.
// Inserts shift a cell up from below, deletes shift it down from above.
module swm_cell #(
  parameter int SAMPLE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  swm_pkg::cell_cmd_t            cmd,
  input  logic signed [SAMPLE_BITS-1:0] new_key,
  input  logic signed [SAMPLE_BITS-1:0] del_key,
  input  logic signed [SAMPLE_BITS-1:0] lo_key,
  input  swm_pkg::cell_flags_t          lo_flags,
  input  logic signed [SAMPLE_BITS-1:0] hi_key,
  input  swm_pkg::cell_flags_t          hi_flags,
  output logic signed [SAMPLE_BITS-1:0] key,
  output swm_pkg::cell_flags_t          flags
);

  logic signed [SAMPLE_BITS-1:0] key_r;
  logic signed [SAMPLE_BITS-1:0] key_nxt;
  logic                          valid_r;
  logic                          valid_nxt;
  logic                          above_del;

  // Local compares against the broadcast keys.
  always_comb begin
    flags.valid = valid_r;
    flags.stay  = valid_r && !(key_r > new_key);
    flags.eq    = valid_r && (key_r == del_key);
    above_del   = valid_r && (key_r > del_key);
  end

  assign key = key_r;

  // Next contents: keep, take the new sample, or take a neighbor.
  always_comb begin
    key_nxt   = key_r;
    valid_nxt = valid_r;
    unique case (cmd)
      swm_pkg::CELL_HOLD: begin
      end
      swm_pkg::CELL_CLEAR: begin
        valid_nxt = 1'b0;
      end
      swm_pkg::CELL_INSERT: begin
        if (flags.stay) begin
          key_nxt = key_r;
        end else if (lo_flags.stay) begin
          key_nxt   = new_key;
          valid_nxt = 1'b1;
        end else begin
          key_nxt   = lo_key;
          valid_nxt = lo_flags.valid;
        end
      end
      swm_pkg::CELL_DELETE: begin
        // The top copy of the leaving value goes, cells above it move down.
        if (above_del || (flags.eq && !hi_flags.eq)) begin
          key_nxt   = hi_key;
          valid_nxt = hi_flags.valid;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

/* design/swm_row.sv */
// Row of sorted cells holding the window in ascending order.
// Depends on swm_pkg and swm_cell; selects the sample at the median rank.
module swm_row #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 32,
  parameter int IDX_W       = 6
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  swm_pkg::cell_cmd_t            cmd,
  input  logic signed [SAMPLE_BITS-1:0] new_key,
  input  logic signed [SAMPLE_BITS-1:0] del_key,
  input  logic [IDX_W-1:0]              rank,
  output logic signed [SAMPLE_BITS-1:0] rank_key
);

  logic signed [SAMPLE_BITS-1:0] keys [WINDOW_MAX];
  swm_pkg::cell_flags_t          flags [WINDOW_MAX];

  // Chain of cells; the ends see a fixed boundary.
  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] lo_key;
    logic signed [SAMPLE_BITS-1:0] hi_key;
    swm_pkg::cell_flags_t          lo_flags;
    swm_pkg::cell_flags_t          hi_flags;

    if (i == 0) begin : g_bottom
      assign lo_key   = '0;
      assign lo_flags = '{valid: 1'b1, stay: 1'b1, eq: 1'b0};
    end else begin : g_lo
      assign lo_key   = keys[i-1];
      assign lo_flags = flags[i-1];
    end

    if (i == WINDOW_MAX - 1) begin : g_top
      assign hi_key   = '0;
      assign hi_flags = '0;
    end else begin : g_hi
      assign hi_key   = keys[i+1];
      assign hi_flags = flags[i+1];
    end

    swm_cell #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd),
      .new_key (new_key),
      .del_key (del_key),
      .lo_key  (lo_key),
      .lo_flags(lo_flags),
      .hi_key  (hi_key),
      .hi_flags(hi_flags),
      .key     (keys[i]),
      .flags   (flags[i])
    );
  end

  // Sample at the median rank.
  assign rank_key = keys[rank];

endmodule

/* design/swm_ring.sv */
// Arrival ring: the window samples in arrival order.
// No package dependency; one write port and one registered read port.
module swm_ring #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* design/sliding_window_median.sv */
// Top level of the sliding window median filter.
// Depends on swm_pkg, swm_row (sorted cell row) and swm_ring (arrival ring).
//
//   Channel  Ports                      Carries
//   input    in_tvalid/tready/tdata     tdata: sample; tuser: start_new
//   result   out_tvalid/tready/tdata    tdata: median (lower median)
//   config   cfg_wr_en/cfg_wr_data      window_size, 7 bits
//
// While the window fills, an item passes accept, check and insert; the item
// that completes the window passes the result state too. Once it is full, a
// check and a delete come first, as the oldest sample is read from the ring
// and removed from the cell row; each further sample removed after the window
// size was lowered adds one more check and delete. Reset is synchronous and
// empties the window. A new result waits in the result state while the previous
// one is still stalled at the output, and no item is taken until it is loaded.
module sliding_window_median #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  // Input item.
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]         in_tdata,   // [SAMPLE_BITS-1:0] sample
  input  logic                                     in_tuser,   // [0] start_new
  // Result item.
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]         out_tdata,  // [SAMPLE_BITS-1:0] median
  // Window size register.
  input  logic                                     cfg_wr_en,
  input  logic [swm_pkg::WSIZE_BITS-1:0]           cfg_wr_data
);

  localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int FILL_W = $clog2(WINDOW_MAX + 1);
  localparam int PTR_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int KW     = (FILL_W > swm_pkg::WSIZE_BITS) ? FILL_W : swm_pkg::WSIZE_BITS;
  localparam int OW     = FILL_W + 1;

  swm_pkg::state_t               state_r;
  swm_pkg::state_t               state_nxt;
  logic [swm_pkg::WSIZE_BITS-1:0] wsize_r;
  logic [FILL_W-1:0]             fill_r;
  logic [FILL_W-1:0]             fill_nxt;
  logic [PTR_W-1:0]              ptr_r;
  logic [PTR_W-1:0]              ptr_nxt;
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic signed [SAMPLE_BITS-1:0] median_r;
  logic                          out_valid_r;
  logic                          out_valid_nxt;
  logic                          load_result;

  logic                          in_accept;
  logic [KW-1:0]                 wsize_ext;
  logic [KW-1:0]                 k_ext;
  logic [FILL_W-1:0]             k;
  logic [FILL_W-1:0]             k_minus1;
  logic [PTR_W-1:0]              rank;
  logic [OW-1:0]                 oldest_sum;
  logic [PTR_W-1:0]              oldest;
  logic                          window_full;
  logic                          fills_now;

  swm_pkg::cell_cmd_t            cell_cmd;
  logic signed [SAMPLE_BITS-1:0] rank_key;
  logic                          ring_wr;
  logic                          ring_rd;
  logic [SAMPLE_BITS-1:0]        ring_rd_data;

  assign in_accept = in_tvalid && in_tready;

  // Effective window size: zero counts as one, large values saturate.
  always_comb begin
    wsize_ext = KW'(wsize_r);
    if (wsize_ext == '0) begin
      k_ext = KW'(1);
    end else if (wsize_ext > KW'(WINDOW_MAX)) begin
      k_ext = KW'(WINDOW_MAX);
    end else begin
      k_ext = wsize_ext;
    end
    k        = k_ext[FILL_W-1:0];
    k_minus1 = k - FILL_W'(1);
    rank     = PTR_W'(k_minus1 >> 1);
  end

  // Ring slot of the oldest sample, ptr - fill modulo the ring depth.
  always_comb begin
    oldest_sum = OW'(ptr_r) + OW'(WINDOW_MAX) - OW'(fill_r);
    if (oldest_sum >= OW'(WINDOW_MAX)) begin
      oldest_sum = oldest_sum - OW'(WINDOW_MAX);
    end
    oldest = oldest_sum[PTR_W-1:0];
  end

  assign window_full = (fill_r >= k);
  assign fills_now   = ((fill_r + FILL_W'(1)) == k);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      swm_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_nxt = swm_pkg::ST_CHECK;
        end
      end
      swm_pkg::ST_CHECK: begin
        state_nxt = window_full ? swm_pkg::ST_DELETE : swm_pkg::ST_INSERT;
      end
      swm_pkg::ST_DELETE: begin
        state_nxt = swm_pkg::ST_CHECK;
      end
      swm_pkg::ST_INSERT: begin
        state_nxt = fills_now ? swm_pkg::ST_RESULT : swm_pkg::ST_IDLE;
      end
      swm_pkg::ST_RESULT: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = swm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = swm_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath controls per state.
  always_comb begin
    in_tready   = 1'b0;
    cell_cmd    = swm_pkg::CELL_HOLD;
    ring_wr     = 1'b0;
    ring_rd     = 1'b0;
    fill_nxt    = fill_r;
    ptr_nxt     = ptr_r;
    load_result = 1'b0;
    unique case (state_r)
      swm_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_accept && in_tuser) begin
          cell_cmd = swm_pkg::CELL_CLEAR;
          fill_nxt = '0;
          ptr_nxt  = '0;
        end
      end
      swm_pkg::ST_CHECK: begin
        ring_rd = window_full;
      end
      swm_pkg::ST_DELETE: begin
        cell_cmd = swm_pkg::CELL_DELETE;
        fill_nxt = fill_r - FILL_W'(1);
      end
      swm_pkg::ST_INSERT: begin
        cell_cmd = swm_pkg::CELL_INSERT;
        ring_wr  = 1'b1;
        fill_nxt = fill_r + FILL_W'(1);
        ptr_nxt  = (ptr_r == PTR_W'(WINDOW_MAX - 1)) ? '0 : ptr_r + PTR_W'(1);
      end
      swm_pkg::ST_RESULT: begin
        load_result = !out_valid_r || out_tready;
      end
      default: begin
      end
    endcase
  end

  // Output register valid: set by a new result, cleared when taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_result) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= swm_pkg::ST_IDLE;
      fill_r      <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
      wsize_r     <= swm_pkg::WSIZE_RESET;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        wsize_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      sample_r <= $signed(in_tdata[SAMPLE_BITS-1:0]);
    end
    if (load_result) begin
      median_r <= rank_key;
    end
  end

  swm_row #(
    .WINDOW_MAX (WINDOW_MAX),
    .SAMPLE_BITS(SAMPLE_BITS),
    .IDX_W      (PTR_W)
  ) u_row (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cell_cmd),
    .new_key (sample_r),
    .del_key ($signed(ring_rd_data)),
    .rank    (rank),
    .rank_key(rank_key)
  );

  swm_ring #(
    .DEPTH(WINDOW_MAX),
    .WIDTH(SAMPLE_BITS),
    .AW   (PTR_W)
  ) u_ring (
    .clk    (clk),
    .wr_en  (ring_wr),
    .wr_addr(ptr_r),
    .wr_data(sample_r),
    .rd_en  (ring_rd),
    .rd_addr(oldest),
    .rd_data(ring_rd_data)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = DATA_W'($unsigned(median_r));

endmodule

/* design/swm_checker.sv */
// Port-level checker for the sliding window median filter, bound to the top.
// Depends on nothing but the top level's ports.
module swm_checker #(
  parameter int DATA_W = 32
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [DATA_W-1:0] out_tdata
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // The input stays held off while an item is worked on, before the next is taken.
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready ##1 !in_tready)
    else $error("next item taken too early");

  // A new result only appears while the input side is held off.
  a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result appeared while idle");

  // Reset empties the output register.
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind sliding_window_median swm_checker #(
  .DATA_W(((SAMPLE_BITS + 7) / 8) * 8)
) u_swm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

/* sim/tb_top.sv */
// Self-checking testbench for the sliding window median filter.
// Drives sample streams under several window sizes and compares every median with a
// predictor kept in this file. Depends on swm_pkg and sliding_window_median.
module tb_top;

  localparam int WINDOW_MAX    = 64;
  localparam int SAMPLE_W      = 32;
  localparam int DATA_W        = ((SAMPLE_W + 7) / 8) * 8;
  localparam int LIMIT_CYCLES  = 1_000_000;
  // Worst item: one insert plus removal of every sample after a big shrink.
  localparam int SETTLE_CYCLES = 200;
  localparam int LONG_HOLD     = 400;
  localparam int MAX_REPORTS   = 10;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [swm_pkg::WSIZE_BITS-1:0] wsize_t;

  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata;   // [SAMPLE_W-1:0] sample
  logic              in_tuser;   // [0] start_new
  logic              out_tvalid;
  logic              out_tready;
  logic [DATA_W-1:0] out_tdata;  // [SAMPLE_W-1:0] median
  logic              cfg_wr_en;
  wsize_t            cfg_wr_data;

  // Medians still owed by the block, oldest first.
  sample_t pending_medians[$];
  int      err_count = 0;
  int      cycle_count = 0;
  bit      tx_gaps_on = 1'b1;
  bit      rx_stalls_on = 1'b1;
  bit      hold_request = 1'b0;

  sliding_window_median #(
    .WINDOW_MAX (WINDOW_MAX),
    .SAMPLE_BITS(SAMPLE_W)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit: a hung block ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d medians outstanding",
               cycle_count, pending_medians.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Gap length: mostly short, now and then a long pause.
  function automatic int unsigned gap_len();
    if ($urandom_range(0, 19) < 17) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Sample mix: extremes, a narrow band that forces equal values, and full range.
  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       return SAMPLE_MIN;
          1:       return SAMPLE_MAX;
          2:       return '0;
          default: return '1;
        endcase
      end
      1, 2, 3: return sample_t'(int'($urandom_range(0, 8)) - 4);
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic flag_error(input string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("ERROR: %s", msg);
  endtask

  // Window predictor: the window in arrival order and the same values sorted.
  // It follows input items and register writes as the block sees them.
  always @(posedge clk) begin
    static sample_t win_fifo[$];
    static sample_t win_sorted[$];
    static wsize_t  wsize_reg;
    int unsigned    k;
    int             i;
    sample_t        value;
    sample_t        leaving;
    if (!rst_n) begin
      win_fifo.delete();
      win_sorted.delete();
      wsize_reg = swm_pkg::WSIZE_RESET;
    end else begin
      if (cfg_wr_en) wsize_reg = cfg_wr_data;
      if (in_tvalid && in_tready) begin
        k = (wsize_reg == 0) ? 1 : ((wsize_reg > WINDOW_MAX) ? WINDOW_MAX : wsize_reg);
        value = in_tdata[SAMPLE_W-1:0];
        if (in_tuser) begin
          win_fifo.delete();
          win_sorted.delete();
        end
        // Oldest samples leave until there is room; one copy of each value goes.
        while (win_fifo.size() >= k) begin
          leaving = win_fifo.pop_front();
          i = 0;
          while (win_sorted[i] != leaving) i++;
          win_sorted.delete(i);
        end
        win_fifo.insert(win_fifo.size(), value);
        i = 0;
        while (i < win_sorted.size() && win_sorted[i] <= value) i++;
        win_sorted.insert(i, value);
        if (win_fifo.size() == k) begin
          pending_medians.insert(pending_medians.size(), win_sorted[(k + 1) / 2 - 1]);
        end
      end
    end
  end

  // Result checker: each median against the oldest one predicted.
  always @(posedge clk) begin
    sample_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_medians.size() == 0) begin
        flag_error($sformatf("median %0d with none predicted",
                             $signed(out_tdata[SAMPLE_W-1:0])));
      end else begin
        want = pending_medians.pop_front();
        if (out_tdata[SAMPLE_W-1:0] !== want) begin
          flag_error($sformatf("median expected %0d, got %0d",
                               want, $signed(out_tdata[SAMPLE_W-1:0])));
        end
      end
    end
  end

  // Receiver: random stalls, or one long hold when a test asks for it.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else if (rx_stalls_on && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat (gap_len() - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Offer one item and wait until the block takes it.
  task automatic send_item(input logic start, input sample_t value);
    int unsigned gap;
    gap = (tx_gaps_on && $urandom_range(0, 3) == 0) ? gap_len() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tuser  <= start;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Stop offering, wait for every predicted median, then let the block settle.
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_medians.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_window(input wsize_t size);
    wait_drained();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= size;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Random stream; start flags appear at the given rate per thousand items.
  task automatic run_stream(input int n, input int start_pm, input bit lead_start);
    logic start;
    for (int i = 0; i < n; i++) begin
      start = (i == 0 && lead_start) || ($urandom_range(0, 999) < start_pm);
      send_item(start, pick_sample());
    end
  endtask

  // Reset window of three: extremes, equal samples, a restart mid-stream.
  task automatic test_directed();
    send_item(1'b1, SAMPLE_MAX);
    send_item(1'b0, SAMPLE_MIN);
    send_item(1'b0, '0);
    send_item(1'b0, '1);
    send_item(1'b0, '1);
    send_item(1'b0, '1);
    send_item(1'b0, SAMPLE_MAX);
    send_item(1'b0, SAMPLE_MAX);
    send_item(1'b1, sample_t'(5));
    send_item(1'b0, sample_t'(5));
    send_item(1'b0, sample_t'(-5));
    send_item(1'b0, SAMPLE_MIN);
  endtask

  // A window size of zero acts as a window of one sample.
  task automatic test_window_zero();
    set_window('0);
    send_item(1'b1, SAMPLE_MIN);
    send_item(1'b0, SAMPLE_MAX);
    send_item(1'b0, '0);
    send_item(1'b1, '1);
    send_item(1'b0, sample_t'(32'h5555_aaaa));
    send_item(1'b0, sample_t'(32'haaaa_5555));
  endtask

  task automatic test_window_one();
    set_window(wsize_t'(1));
    run_stream(60, 50, 1'b0);
  endtask

  task automatic test_window_max();
    set_window(wsize_t'(WINDOW_MAX));
    run_stream(200, 3, 1'b1);
  endtask

  // Sizes above the maximum saturate; the full window carries on unchanged.
  task automatic test_window_oversize();
    set_window('1);
    run_stream(100, 0, 1'b0);
  endtask

  // Lowering the size without a restart drops the oldest samples first.
  task automatic test_shrink_midstream();
    set_window(wsize_t'(5));
    run_stream(100, 20, 1'b0);
  endtask

  // Raising the size mid-stream withholds results until the window refills.
  task automatic test_grow_midstream();
    set_window(wsize_t'(40));
    run_stream(120, 5, 1'b0);
  endtask

  // The receiver holds off while items keep coming, so the input stalls.
  task automatic test_backpressure();
    set_window(wsize_t'(4));
    tx_gaps_on   = 1'b0;
    hold_request = 1'b1;
    run_stream(150, 30, 1'b1);
    tx_gaps_on = 1'b1;
  endtask

  task automatic test_random_windows();
    wsize_t size;
    for (int p = 0; p < 6; p++) begin
      case ($urandom_range(0, 5))
        0:       size = wsize_t'($urandom_range(WINDOW_MAX + 1, 127));
        1:       size = wsize_t'($urandom_range(30, WINDOW_MAX));
        default: size = wsize_t'($urandom_range(0, 16));
      endcase
      set_window(size);
      run_stream(70, 25, 1'($urandom_range(0, 1)));
    end
  endtask

  // Back-to-back items with an always-ready receiver.
  task automatic test_no_idle();
    set_window(wsize_t'(7));
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    run_stream(100, 15, 1'b1);
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_window_zero();
    test_window_one();
    test_window_max();
    test_window_oversize();
    test_shrink_midstream();
    test_grow_midstream();
    test_backpressure();
    test_random_windows();
    test_no_idle();
    wait_drained();

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/swm_pkg.sv
design/swm_cell.sv
design/swm_row.sv
design/swm_ring.sv
design/sliding_window_median.sv
design/swm_checker.sv
sim/tb_top.sv
